// File: design/xcrc_pkg.sv
package xcrc_pkg;

  // Widths of the result fields, fixed by the interface.
  localparam int AddrBits       = 24;
  localparam int LenBits        = 11;
  localparam int OffsetBitsDflt = 24;

  // Result queue depth; must be a power of two and at least two.
  localparam int QueueDepth = 4;

  localparam logic [LenBits-1:0] LenShort = 11'd128;
  localparam logic [LenBits-1:0] LenLong  = 11'd1024;

  localparam logic [15:0] CrcPoly = 16'h1021;

  // Line characters.
  localparam logic [7:0] ChSoh = 8'h01;
  localparam logic [7:0] ChStx = 8'h02;
  localparam logic [7:0] ChEot = 8'h04;
  localparam logic [7:0] ChAck = 8'h06;
  localparam logic [7:0] ChNak = 8'h15;
  localparam logic [7:0] ChC   = 8'h43;

  typedef enum logic [1:0] {
    FUNC_BYTE  = 2'd0,
    FUNC_IDLE  = 2'd1,
    FUNC_START = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_SEND   = 2'd0,
    KIND_STAGE  = 2'd1,
    KIND_COMMIT = 2'd2,
    KIND_DONE   = 2'd3
  } kind_e;

  typedef enum logic [7:0] {
    PH_DONE  = 8'b0000_0001,
    PH_WAIT  = 8'b0000_0010,
    PH_BLK   = 8'b0000_0100,
    PH_CMP   = 8'b0000_1000,
    PH_DATA  = 8'b0001_0000,
    PH_CRCH  = 8'b0010_0000,
    PH_CRCL  = 8'b0100_0000,
    PH_DRAIN = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    kind_e                kind;
    logic [7:0]           byte_value;
    logic [AddrBits-1:0]  address;
    logic [LenBits-1:0]   block_len;
    logic                 last;
  } res_t;

  // Up to two results written into the queue in one cycle.
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } wr_t;

  function automatic res_t mk_res(kind_e kind, logic [7:0] val,
                                  logic [AddrBits-1:0] addr,
                                  logic [LenBits-1:0] len, logic last);
    res_t r;
    r.kind       = kind;
    r.byte_value = val;
    r.address    = addr;
    r.block_len  = len;
    r.last       = last;
    return r;
  endfunction

  // CRC-16 update by one byte, MSB first, as an unrolled XOR network.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: design/xcrc_front.sv
module xcrc_front #(
  parameter int OffsetBits = xcrc_pkg::OffsetBitsDflt
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  logic [1:0]      func_i,
  input  logic [7:0]      rx_byte_i,
  output xcrc_pkg::wr_t   wr_o
);
  import xcrc_pkg::*;

  localparam int ExtBits = OffsetBits + AddrBits;

  phase_e                phase_q, phase_d;
  logic [7:0]            pend_q, pend_d;
  logic [7:0]            exp_q, exp_d;
  logic [OffsetBits-1:0] blk_off_q, blk_off_d;
  logic [OffsetBits-1:0] next_off_q, next_off_d;
  logic                  long_q, long_d;
  logic [7:0]            got_blk_q, got_blk_d;
  logic [7:0]            got_cmp_q, got_cmp_d;
  logic [LenBits-1:0]    cnt_q, cnt_d;
  logic [15:0]           crc_q, crc_d;
  logic [7:0]            crc_hi_q, crc_hi_d;

  logic [LenBits-1:0]    pkt_len;
  logic [LenBits-1:0]    cnt_inc;
  logic [7:0]            next_blk;
  logic                  is_next;
  logic [OffsetBits-1:0] base;
  logic [OffsetBits-1:0] stage_off;
  logic [AddrBits-1:0]   stage_addr;
  logic [AddrBits-1:0]   base_addr;
  logic [ExtBits-1:0]    stage_ext;
  logic [ExtBits-1:0]    base_ext;
  logic                  pkt_ok;

  assign pkt_len    = long_q ? LenLong : LenShort;
  assign cnt_inc    = cnt_q + 11'd1;
  assign next_blk   = exp_q + 8'd1;
  assign is_next    = (got_blk_q == next_blk);
  assign base       = is_next ? next_off_q : blk_off_q;
  assign stage_off  = base + {{(OffsetBits-LenBits){1'b0}}, cnt_q};
  // Offsets may be narrower or wider than the address port.
  assign stage_ext  = {{AddrBits{1'b0}}, stage_off};
  assign base_ext   = {{AddrBits{1'b0}}, base};
  assign stage_addr = stage_ext[AddrBits-1:0];
  assign base_addr  = base_ext[AddrBits-1:0];
  assign pkt_ok     = (got_blk_q == ~got_cmp_q)
                      && ((got_blk_q == exp_q) || is_next)
                      && ({crc_hi_q, rx_byte_i} == crc_q);

  always_comb begin
    phase_d    = phase_q;
    pend_d     = pend_q;
    exp_d      = exp_q;
    blk_off_d  = blk_off_q;
    next_off_d = next_off_q;
    long_d     = long_q;
    got_blk_d  = got_blk_q;
    got_cmp_d  = got_cmp_q;
    cnt_d      = cnt_q;
    crc_d      = crc_q;
    crc_hi_d   = crc_hi_q;
    wr_o.count = 2'd0;
    wr_o.r0    = mk_res(KIND_SEND, 8'h00, '0, '0, 1'b1);
    wr_o.r1    = mk_res(KIND_SEND, 8'h00, '0, '0, 1'b1);

    if (take_i) begin
      case (func_i)
        FUNC_START: begin
          phase_d    = PH_WAIT;
          pend_d     = ChC;
          exp_d      = 8'd1;
          blk_off_d  = '0;
          next_off_d = '0;
          long_d     = 1'b0;
          got_blk_d  = '0;
          got_cmp_d  = '0;
          cnt_d      = '0;
          crc_d      = '0;
          crc_hi_d   = '0;
          wr_o.count = 2'd1;
          wr_o.r0    = mk_res(KIND_SEND, ChC, '0, '0, 1'b1);
        end
        FUNC_IDLE: begin
          if (phase_q == PH_WAIT) begin
            wr_o.count = 2'd1;
            wr_o.r0    = mk_res(KIND_SEND, pend_q, '0, '0, 1'b1);
          end else if (phase_q == PH_DRAIN) begin
            // Until a committed block has moved the offset on, the sender is still invited.
            pend_d     = (blk_off_q == '0) ? ChC : ChNak;
            phase_d    = PH_WAIT;
            wr_o.count = 2'd1;
            wr_o.r0    = mk_res(KIND_SEND, pend_d, '0, '0, 1'b1);
          end
        end
        FUNC_BYTE: begin
          case (phase_q)
            PH_WAIT: begin
              if (rx_byte_i == ChSoh || rx_byte_i == ChStx) begin
                long_d  = (rx_byte_i == ChStx);
                phase_d = PH_BLK;
              end else if (rx_byte_i == ChEot) begin
                phase_d    = PH_DONE;
                wr_o.count = 2'd2;
                wr_o.r0    = mk_res(KIND_SEND, ChAck, '0, '0, 1'b0);
                wr_o.r1    = mk_res(KIND_DONE, 8'h00, '0, '0, 1'b1);
              end else begin
                phase_d = PH_DRAIN;
              end
            end
            PH_BLK: begin
              got_blk_d = rx_byte_i;
              phase_d   = PH_CMP;
            end
            PH_CMP: begin
              got_cmp_d = rx_byte_i;
              crc_d     = '0;
              cnt_d     = '0;
              phase_d   = PH_DATA;
            end
            PH_DATA: begin
              wr_o.count = 2'd1;
              wr_o.r0    = mk_res(KIND_STAGE, rx_byte_i, stage_addr, '0, 1'b1);
              crc_d      = crc_byte(crc_q, rx_byte_i);
              cnt_d      = cnt_inc;
              if (cnt_inc >= pkt_len) begin
                phase_d = PH_CRCH;
              end
            end
            PH_CRCH: begin
              crc_hi_d = rx_byte_i;
              phase_d  = PH_CRCL;
            end
            PH_CRCL: begin
              phase_d = PH_WAIT;
              if (pkt_ok) begin
                if (is_next) begin
                  blk_off_d = next_off_q;
                  exp_d     = next_blk;
                end
                next_off_d = base + {{(OffsetBits-LenBits){1'b0}}, pkt_len};
                pend_d     = ChAck;
                wr_o.count = 2'd2;
                wr_o.r0    = mk_res(KIND_COMMIT, 8'h00, base_addr, pkt_len, 1'b0);
                wr_o.r1    = mk_res(KIND_SEND, ChAck, '0, '0, 1'b1);
              end else begin
                pend_d     = ChNak;
                wr_o.count = 2'd1;
                wr_o.r0    = mk_res(KIND_SEND, ChNak, '0, '0, 1'b1);
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_DONE;
      pend_q     <= ChC;
      exp_q      <= 8'd1;
      blk_off_q  <= '0;
      next_off_q <= '0;
      long_q     <= 1'b0;
      got_blk_q  <= '0;
      got_cmp_q  <= '0;
      cnt_q      <= '0;
      crc_q      <= '0;
      crc_hi_q   <= '0;
    end else begin
      phase_q    <= phase_d;
      pend_q     <= pend_d;
      exp_q      <= exp_d;
      blk_off_q  <= blk_off_d;
      next_off_q <= next_off_d;
      long_q     <= long_d;
      got_blk_q  <= got_blk_d;
      got_cmp_q  <= got_cmp_d;
      cnt_q      <= cnt_d;
      crc_q      <= crc_d;
      crc_hi_q   <= crc_hi_d;
    end
  end

endmodule

// File: design/xcrc_queue.sv
module xcrc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  xcrc_pkg::wr_t  wr_i,
  input  logic           pop_i,
  output xcrc_pkg::res_t head_o,
  output logic           empty_o,
  output logic           full_o
);
  import xcrc_pkg::*;

  localparam int PtrBits = $clog2(QueueDepth);
  localparam int CntBits = $clog2(QueueDepth + 1);

  res_t               mem_q [QueueDepth];
  logic [PtrBits-1:0] wptr_q, wptr_d;
  logic [PtrBits-1:0] rptr_q, rptr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [PtrBits-1:0] wptr_nxt;
  logic               pop_ok;

  assign empty_o  = (cnt_q == '0);
  // Room for a two-result request must always be left.
  assign full_o   = (cnt_q > CntBits'(QueueDepth - 2));
  assign head_o   = mem_q[rptr_q];
  assign pop_ok   = pop_i && !empty_o;
  assign wptr_nxt = wptr_q + PtrBits'(1);
  assign wptr_d   = wptr_q + PtrBits'(wr_i.count);
  assign rptr_d   = rptr_q + PtrBits'(pop_ok);
  assign cnt_d    = cnt_q + CntBits'(wr_i.count) - CntBits'(pop_ok);

  always_ff @(posedge clk_i) begin
    if (wr_i.count != 2'd0) begin
      mem_q[wptr_q] <= wr_i.r0;
    end
    if (wr_i.count == 2'd2) begin
      mem_q[wptr_nxt] <= wr_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// File: design/xmodem_crc_receiver.sv
// XMODEM-CRC receiver.
// Requests enter through a queue-like port: func_i and rx_byte_i are taken
// at a rising edge with push high and full low. A line byte, an idle tick or
// a start request is decoded by the protocol engine in that same cycle, which
// writes zero, one or two results into a small result queue.
// Results leave through empty and pop: while empty is low the oldest result
// sits on kind_o, byte_value_o, address_o, block_len_o and last_o, and it is
// taken at an edge with pop high. last_o marks the final result of a request.
// The results of a request are written into the result queue as it is taken.
// Throughput is one request per cycle while results are popped as fast as
// they appear; the single read port of the result queue sets this, so a
// request giving two results (commit plus ACK, or ACK plus done) adds one
// result of backlog.
// full rises when the queue cannot take two more results; if the receiver
// stops popping, the queue fills and push is held off without loss.
// After reset the block waits for a start request, the queue is empty and
// offsets restart from zero with block one expected.
module xmodem_crc_receiver #(
  parameter int OffsetBits = xcrc_pkg::OffsetBitsDflt
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    func_i,
  input  logic [7:0]                    rx_byte_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    kind_o,
  output logic [7:0]                    byte_value_o,
  output logic [xcrc_pkg::AddrBits-1:0] address_o,
  output logic [xcrc_pkg::LenBits-1:0]  block_len_o,
  output logic                          last_o
);
  import xcrc_pkg::*;

  wr_t  wr;
  res_t head;
  logic take;

  // A request is taken only when the queue has room for both its results.
  assign take = push && !full;

  xcrc_front #(
    .OffsetBits(OffsetBits)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .func_i   (func_i),
    .rx_byte_i(rx_byte_i),
    .wr_o     (wr)
  );

  xcrc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(empty),
    .full_o (full)
  );

  assign kind_o       = head.kind;
  assign byte_value_o = head.byte_value;
  assign address_o    = head.address;
  assign block_len_o  = head.block_len;
  assign last_o       = head.last;

  // A committed block is always a short or a long packet.
  a_commit_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_COMMIT) |-> (block_len_o == LenShort || block_len_o == LenLong))
    else $error("commit result with a bad block length");

  // Only a commit carries a block length.
  a_len_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_COMMIT) |-> (block_len_o == '0))
    else $error("non-commit result with a block length");

  // A start request always leaves a result waiting.
  a_start_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && func_i == FUNC_START) |=> !empty)
    else $error("start request gave no result");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the XMODEM-CRC receiver.
// Requests (line bytes, idle ticks, start requests) are held in a queue and
// offered to the block whenever the sending side is not idling. Every request
// that the block accepts is also run through a predictor kept in this module,
// which appends the results it expects to a queue. The receiving side pops
// results at random and compares each one, field by field, with the oldest
// expectation.
module tb;
  import xcrc_pkg::*;

  // The slowest correct run has a few thousand requests and two results per
  // request at most, so this limit leaves a wide margin.
  localparam int unsigned CycleLimit = 400000;
  localparam int          NumPhases  = 4;
  localparam int          TailCycles = 8;
  localparam res_t        NoRes      = '0;

  // One request as it is queued for the driver. Rows of the directed table
  // may carry their expected results typed in; all others are predicted.
  typedef struct {
    func_e      func;
    logic [7:0] rx;
    bit         typed;
    int         n_res;
    res_t       r0;
    res_t       r1;
  } req_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic [1:0]          func_i = 2'd0;
  logic [7:0]          rx_byte = 8'd0;
  logic                empty;
  logic                pop = 1'b0;
  logic [1:0]          kind_o;
  logic [7:0]          byte_value_o;
  logic [AddrBits-1:0] address_o;
  logic [LenBits-1:0]  block_len_o;
  logic                last_o;

  req_t        req_q [$];
  res_t        expected_q [$];
  req_t        cur_req;
  int unsigned queued_total = 0;
  int unsigned accepted_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Predictor state: a copy of what the receiver holds between requests.
  phase_e              st;
  logic [7:0]          cmd_byte;
  logic [7:0]          want_blk;
  logic [AddrBits-1:0] blk_base;
  logic [AddrBits-1:0] blk_next;
  logic                is_long;
  logic [7:0]          rx_blk;
  logic [7:0]          rx_cmp;
  logic [LenBits-1:0]  data_cnt;
  logic [15:0]         crc_acc;
  logic [7:0]          crc_hi;

  // Stimulus generator state: the block number it believes comes next.
  logic [7:0] gen_blk;
  bit         gen_done;

  xmodem_crc_receiver u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push        (push),
    .full        (full),
    .func_i      (func_i),
    .rx_byte_i   (rx_byte),
    .empty       (empty),
    .pop         (pop),
    .kind_o      (kind_o),
    .byte_value_o(byte_value_o),
    .address_o   (address_o),
    .block_len_o (block_len_o),
    .last_o      (last_o)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic res_t result_of(kind_e k, logic [7:0] v, logic [AddrBits-1:0] a,
                                     logic [LenBits-1:0] l, logic lst);
    res_t r;
    r.kind       = k;
    r.byte_value = v;
    r.address    = a;
    r.block_len  = l;
    r.last       = lst;
    return r;
  endfunction

  function automatic req_t free_row(func_e f, logic [7:0] b);
    req_t q;
    q.func  = f;
    q.rx    = b;
    q.typed = 1'b0;
    q.n_res = 0;
    q.r0    = NoRes;
    q.r1    = NoRes;
    return q;
  endfunction

  function automatic req_t typed_row(func_e f, logic [7:0] b, int n,
                                     res_t r0 = NoRes, res_t r1 = NoRes);
    req_t q;
    q       = free_row(f, b);
    q.typed = 1'b1;
    q.n_res = n;
    q.r0    = r0;
    q.r1    = r1;
    return q;
  endfunction

  // CRC-16 with polynomial 0x1021, fed one data bit at a time, MSB first.
  function automatic logic [15:0] crc16_feed(logic [15:0] crc, logic [7:0] d);
    logic [15:0] c;
    int          i;
    c = crc;
    for (i = 7; i >= 0; i--) begin
      if (c[15] ^ d[i]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  task automatic clear_receiver();
    st       = PH_DONE;
    cmd_byte = ChC;
    want_blk = 8'd1;
    blk_base = '0;
    blk_next = '0;
    is_long  = 1'b0;
    rx_blk   = 8'd0;
    rx_cmp   = 8'd0;
    data_cnt = '0;
    crc_acc  = 16'd0;
    crc_hi   = 8'd0;
  endtask

  // Works out what one accepted request produces and queues it up.
  task automatic predict_request(input req_t rq);
    res_t                out [2];
    int                  n;
    logic [7:0]          succ;
    logic [AddrBits-1:0] base;
    logic [LenBits-1:0]  len;
    bit                  ok;
    n    = 0;
    succ = want_blk + 8'd1;
    len  = is_long ? LenLong : LenShort;
    case (rq.func)
      FUNC_START: begin
        clear_receiver();
        st = PH_WAIT;
        out[n++] = result_of(KIND_SEND, ChC, '0, '0, 1'b0);
      end
      FUNC_IDLE: begin
        if (st == PH_WAIT) begin
          out[n++] = result_of(KIND_SEND, cmd_byte, '0, '0, 1'b0);
        end else if (st == PH_DRAIN) begin
          // A broken header asks again for CRC mode until a block has moved
          // the offset on, and for a resend after that.
          cmd_byte = (blk_base == '0) ? ChC : ChNak;
          st = PH_WAIT;
          out[n++] = result_of(KIND_SEND, cmd_byte, '0, '0, 1'b0);
        end
      end
      FUNC_BYTE: begin
        case (st)
          PH_WAIT: begin
            if (rq.rx == ChSoh || rq.rx == ChStx) begin
              is_long = (rq.rx == ChStx);
              st = PH_BLK;
            end else if (rq.rx == ChEot) begin
              st = PH_DONE;
              out[n++] = result_of(KIND_SEND, ChAck, '0, '0, 1'b0);
              out[n++] = result_of(KIND_DONE, 8'd0, '0, '0, 1'b0);
            end else begin
              st = PH_DRAIN;
            end
          end
          PH_BLK: begin
            rx_blk = rq.rx;
            st = PH_CMP;
          end
          PH_CMP: begin
            rx_cmp   = rq.rx;
            crc_acc  = 16'd0;
            data_cnt = '0;
            st = PH_DATA;
          end
          PH_DATA: begin
            base = (rx_blk == succ) ? blk_next : blk_base;
            out[n++] = result_of(KIND_STAGE, rq.rx, base + AddrBits'(data_cnt), '0, 1'b0);
            crc_acc  = crc16_feed(crc_acc, rq.rx);
            data_cnt = data_cnt + 11'd1;
            if (data_cnt >= len) begin
              st = PH_CRCH;
            end
          end
          PH_CRCH: begin
            crc_hi = rq.rx;
            st = PH_CRCL;
          end
          PH_CRCL: begin
            ok = (rx_blk == ~rx_cmp) && (rx_blk == want_blk || rx_blk == succ)
                 && ({crc_hi, rq.rx} == crc_acc);
            if (ok) begin
              if (rx_blk == succ) begin
                blk_base = blk_next;
                want_blk = succ;
              end
              out[n++] = result_of(KIND_COMMIT, 8'd0, blk_base, len, 1'b0);
              blk_next = blk_base + AddrBits'(len);
              cmd_byte = ChAck;
            end else begin
              cmd_byte = ChNak;
            end
            out[n++] = result_of(KIND_SEND, cmd_byte, '0, '0, 1'b0);
            st = PH_WAIT;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    if (n > 0) begin
      out[n-1].last = 1'b1;
    end
    if (rq.typed) begin
      if (rq.n_res > 0) begin
        expected_q.push_back(rq.r0);
      end
      if (rq.n_res > 1) begin
        expected_q.push_back(rq.r1);
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        expected_q.push_back(out[i]);
      end
    end
  endtask

  task automatic flag_mismatch(input string msg);
    if (err_cnt < 100) begin
      $display("ERROR at %0t ns: %s", $realtime, msg);
    end
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  task automatic queue_req(input func_e f, input logic [7:0] b);
    req_q.push_back(free_row(f, b));
    queued_total++;
  endtask

  // Queues a whole packet with random data. A cut point of zero or more
  // abandons the packet with a start request just before that data byte.
  task automatic queue_packet(input bit long_pkt, input logic [7:0] blk,
                              input logic [7:0] cmp, input bit spoil_crc,
                              input int cut_at);
    logic [15:0] crc;
    logic [7:0]  d;
    int          len;
    len = long_pkt ? 1024 : 128;
    crc = 16'd0;
    queue_req(FUNC_BYTE, long_pkt ? ChStx : ChSoh);
    queue_req(FUNC_BYTE, blk);
    queue_req(FUNC_BYTE, cmp);
    for (int i = 0; i < len; i++) begin
      if (i == cut_at) begin
        queue_req(FUNC_START, 8'($urandom));
        return;
      end
      // The occasional idle tick inside a packet must change nothing.
      if ($urandom_range(99) < 2) begin
        queue_req(FUNC_IDLE, 8'($urandom));
      end
      d = 8'($urandom);
      crc = crc16_feed(crc, d);
      queue_req(FUNC_BYTE, d);
    end
    if (spoil_crc) begin
      crc = crc ^ (16'd1 << $urandom_range(15));
    end
    queue_req(FUNC_BYTE, crc[15:8]);
    queue_req(FUNC_BYTE, crc[7:0]);
  endtask

  // Random traffic for one phase: mostly well-formed short packets, with
  // duplicates, spoilt packets, broken headers, abandoned packets, end of
  // transfer and stray requests mixed in.
  task automatic build_phase(input int unsigned budget, input bit with_long);
    int unsigned first;
    int unsigned pick;
    int unsigned v;
    logic [7:0]  blk;
    logic [7:0]  cmp;
    logic [7:0]  h;
    bit          spoil;
    first = queued_total;
    queue_req(FUNC_START, 8'($urandom));
    gen_blk  = 8'd1;
    gen_done = 1'b0;
    if (with_long) begin
      queue_packet(1'b1, gen_blk, ~gen_blk, 1'b0, -1);
      gen_blk++;
    end
    while (queued_total - first < budget) begin
      pick = $urandom_range(99);
      if (gen_done) begin
        // Requests while the transfer is over are ignored until a start.
        repeat ($urandom_range(3)) begin
          queue_req(func_e'($urandom_range(1) ? FUNC_BYTE : FUNC_IDLE), 8'($urandom));
        end
        queue_req(FUNC_START, 8'($urandom));
        gen_blk  = 8'd1;
        gen_done = 1'b0;
      end else if (pick < 62) begin
        v     = $urandom_range(99);
        blk   = gen_blk;
        cmp   = ~gen_blk;
        spoil = 1'b0;
        if (v < 72) begin
          gen_blk++;
        end else if (v < 80) begin
          blk = gen_blk - 8'd1;
          cmp = ~blk;
        end else if (v < 87) begin
          cmp = cmp ^ (8'd1 << $urandom_range(7));
        end else if (v < 94) begin
          spoil = 1'b1;
        end else begin
          blk = 8'($urandom);
          cmp = ~blk;
        end
        queue_packet(1'b0, blk, cmp, spoil, -1);
        if ($urandom_range(3) == 0) begin
          queue_req(FUNC_IDLE, 8'($urandom));
        end
      end else if (pick < 70) begin
        do begin
          h = 8'($urandom);
        end while (h == ChSoh || h == ChStx || h == ChEot);
        queue_req(FUNC_BYTE, h);
        repeat ($urandom_range(4)) begin
          queue_req(FUNC_BYTE, 8'($urandom));
        end
        queue_req(FUNC_IDLE, 8'($urandom));
      end else if (pick < 76) begin
        queue_packet(1'b1, gen_blk, ~gen_blk, 1'b0, $urandom_range(150));
        gen_blk = 8'd1;
      end else if (pick < 81) begin
        queue_packet(1'b0, gen_blk, ~gen_blk, 1'b0, $urandom_range(127));
        gen_blk = 8'd1;
      end else if (pick < 87) begin
        queue_req(FUNC_BYTE, ChEot);
        gen_done = 1'b1;
      end else if (pick < 94) begin
        queue_req(func_e'($urandom_range(1) ? FUNC_IDLE : FUNC_NONE), 8'($urandom));
      end else begin
        queue_req(FUNC_START, 8'($urandom));
        gen_blk = 8'd1;
      end
    end
  endtask

  task automatic wait_all_accepted();
    while (accepted_cnt != queued_total) begin
      @(posedge clk);
    end
  endtask

  // Sending side. A request stays on the port until it is taken; a new one
  // is offered only once the slot is free and the sender chooses not to idle.
  always @(posedge clk) begin : drive_requests
    if (rst_n) begin
      if (push && !full) begin
        predict_request(cur_req);
        accepted_cnt++;
      end
      if (!push || !full) begin
        if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = req_q.pop_front();
          push    <= 1'b1;
          func_i  <= cur_req.func;
          rx_byte <= cur_req.rx;
        end else begin
          push    <= 1'b0;
          func_i  <= 2'($urandom_range(3));
          rx_byte <= 8'($urandom);
        end
      end
    end
  end

  // Receiving side. Each result taken is checked against the oldest
  // expectation, and pop is then redrawn for the next edge.
  always @(posedge clk) begin : take_results
    res_t want;
    if (rst_n) begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result kind %0d value 0x%0h address 0x%0h",
                                  kind_o, byte_value_o, address_o));
        end else begin
          want = expected_q.pop_front();
          check_field("kind", 32'(kind_o), 32'(want.kind));
          check_field("byte_value", 32'(byte_value_o), 32'(want.byte_value));
          check_field("address", 32'(address_o), 32'(want.address));
          check_field("block_len", 32'(block_len_o), 32'(want.block_len));
          check_field("last", 32'(last_o), 32'(want.last));
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    wait (cycle_cnt >= CycleLimit);
    $display("simulation failed");
    $finish;
  end

  initial begin : run
    req_t        dir_tbl [25];
    int unsigned send_pct [NumPhases];
    int unsigned stall_pct [NumPhases];
    int unsigned budget [NumPhases];
    send_pct  = '{0, 88, 0, 18};
    stall_pct = '{0, 0, 88, 18};
    budget    = '{1100, 250, 250, 250};

    // Directed requests. Results that follow plainly from the protocol are
    // typed in; the other rows of both packets are left to the predictor.
    dir_tbl = '{
      typed_row(FUNC_IDLE, 8'h00, 0),                     // idle while done
      typed_row(FUNC_BYTE, 8'hff, 0),                     // line byte while done
      typed_row(FUNC_NONE, 8'h5a, 0),                     // unused function code
      typed_row(FUNC_START, 8'h00, 1, result_of(KIND_SEND, ChC, '0, '0, 1'b1)),
      typed_row(FUNC_IDLE, 8'hff, 1, result_of(KIND_SEND, ChC, '0, '0, 1'b1)),
      typed_row(FUNC_BYTE, 8'h00, 0),                     // broken header
      typed_row(FUNC_BYTE, ChSoh, 0),                     // dropped while draining
      typed_row(FUNC_IDLE, 8'h00, 1, result_of(KIND_SEND, ChC, '0, '0, 1'b1)),
      typed_row(FUNC_BYTE, ChEot, 2, result_of(KIND_SEND, ChAck, '0, '0, 1'b0),
                result_of(KIND_DONE, 8'h00, '0, '0, 1'b1)),
      typed_row(FUNC_START, 8'hff, 1, result_of(KIND_SEND, ChC, '0, '0, 1'b1)),
      typed_row(FUNC_BYTE, ChSoh, 0),
      typed_row(FUNC_IDLE, 8'h00, 0),                     // idle inside a packet
      free_row(FUNC_BYTE, 8'h01),
      free_row(FUNC_BYTE, 8'hfe),
      typed_row(FUNC_BYTE, 8'h00, 1, result_of(KIND_STAGE, 8'h00, '0, '0, 1'b1)),
      typed_row(FUNC_BYTE, 8'hff, 1, result_of(KIND_STAGE, 8'hff, 24'd1, '0, 1'b1)),
      typed_row(FUNC_NONE, 8'h00, 0),
      typed_row(FUNC_START, 8'h80, 1, result_of(KIND_SEND, ChC, '0, '0, 1'b1)),
      free_row(FUNC_BYTE, ChStx),
      free_row(FUNC_BYTE, 8'h02),                         // next block number
      free_row(FUNC_BYTE, 8'hfd),
      free_row(FUNC_BYTE, 8'h80),
      free_row(FUNC_BYTE, 8'h7f),
      typed_row(FUNC_START, 8'h01, 1, result_of(KIND_SEND, ChC, '0, '0, 1'b1)),
      typed_row(FUNC_BYTE, 8'h03, 0)
    };

    clear_receiver();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i]) begin
      req_q.push_back(dir_tbl[i]);
      queued_total++;
    end

    // Phases: no idling with one full long packet, then a mostly idle
    // sender, then a mostly stalling receiver, then light idling on both.
    for (int p = 0; p < NumPhases; p++) begin
      send_idle_pct  = send_pct[p];
      recv_stall_pct = stall_pct[p];
      build_phase(budget[p], p == 0);
      wait_all_accepted();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_all_accepted();
    while (expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TailCycles) @(posedge clk);

    while (expected_q.size() != 0) begin
      flag_mismatch($sformatf("result never arrived: kind %0d value 0x%0h",
                              expected_q[0].kind, expected_q[0].byte_value));
      void'(expected_q.pop_front());
    end

    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: xmodem_crc_receiver.f
design/xcrc_pkg.sv
design/xcrc_front.sv
design/xcrc_queue.sv
design/xmodem_crc_receiver.sv
tb/tb.sv
